/* rtl/core/netp_pkg.sv */
`timescale 1ns / 1ps

package netp_pkg;

  // Segment code that marks a bundle of moveable entries
  localparam logic [7:0] SEG_MOVEABLE = 8'hFF;
  // Lengths at or below this leave the table unparsed
  localparam logic [15:0] MIN_TABLE_LEN = 16'd2;

  // Where the parser stands inside the current bundle or entry
  typedef enum logic [2:0] {
    PH_COUNT,
    PH_SEG,
    PH_FLAGS,
    PH_SKIP1,
    PH_SKIP2,
    PH_MSEG,
    PH_OFFLO,
    PH_OFFHI
  } phase_t;

  typedef struct packed {
    logic [7:0] table_byte;
    logic       start_of_table;
  } in_beat_t;

  typedef struct packed {
    logic        entry_valid;
    logic [15:0] ordinal;
    logic [7:0]  entry_flags;
    logic [7:0]  entry_segment;
    logic [15:0] entry_offset;
    logic        table_end;
  } out_beat_t;

  // Parser to output buffer: one result beat, when push is set
  typedef struct packed {
    logic      push;
    out_beat_t beat;
  } step_t;

endpackage

/* rtl/core/netp_parser.sv */
`timescale 1ns / 1ps

module netp_parser import netp_pkg::*; #(
  parameter int unsigned MAX_TABLE_BYTES = 32768
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  in_beat_t    in_data,
  input  logic [15:0] table_length,
  output step_t       step
);

  localparam logic [16:0] MaxLen = 17'(MAX_TABLE_BYTES);

  phase_t      phase, phase_next;
  logic [7:0]  bundle_remaining, bundle_remaining_next;
  logic [7:0]  bundle_segment, bundle_segment_next;
  logic [7:0]  flags_latch, flags_latch_next;
  logic [7:0]  segment_latch, segment_latch_next;
  logic [7:0]  offset_low_latch, offset_low_latch_next;
  logic [15:0] byte_position, byte_position_next;
  logic [15:0] ordinal_counter, ordinal_counter_next;
  logic        finished, finished_next;

  logic        start;
  logic        disabled;
  logic        ended;
  logic        entry;
  logic [15:0] offset;
  logic [7:0]  b;

  assign start    = accept && in_data.start_of_table;
  assign b        = in_data.table_byte;
  assign disabled = (table_length <= MIN_TABLE_LEN) || ({1'b0, table_length} > MaxLen);

  // One table byte: restart, length check, then one step of the entry decoder
  always_comb begin
    phase_next            = start ? PH_COUNT : phase;
    bundle_remaining_next = start ? 8'd0 : bundle_remaining;
    bundle_segment_next   = start ? 8'd0 : bundle_segment;
    flags_latch_next      = start ? 8'd0 : flags_latch;
    segment_latch_next    = start ? 8'd0 : segment_latch;
    offset_low_latch_next = start ? 8'd0 : offset_low_latch;
    byte_position_next    = start ? 16'd0 : byte_position;
    ordinal_counter_next  = start ? 16'd0 : ordinal_counter;
    finished_next         = start ? 1'b0 : finished;
    ended  = 1'b0;
    entry  = 1'b0;
    offset = 16'd0;
    step   = '0;

    if (accept && !finished_next) begin
      if (disabled || byte_position_next >= table_length) begin
        // length disabled or already used up
        finished_next       = 1'b1;
        step.push           = 1'b1;
        step.beat.table_end = 1'b1;
      end else begin
        byte_position_next = byte_position_next + 16'd1;
        case (phase_next)
          PH_COUNT: begin
            if (b == 8'd0) begin
              ended = 1'b1;
            end else begin
              bundle_remaining_next = b;
              phase_next            = PH_SEG;
            end
          end
          PH_SEG: begin
            if (b == 8'd0) begin
              ended = 1'b1;
            end else begin
              bundle_segment_next = b;
              phase_next          = PH_FLAGS;
            end
          end
          PH_FLAGS: begin
            flags_latch_next = b;
            if (bundle_segment_next == SEG_MOVEABLE) begin
              phase_next = PH_SKIP1;
            end else begin
              segment_latch_next = bundle_segment_next;
              phase_next         = PH_OFFLO;
            end
          end
          PH_SKIP1: phase_next = PH_SKIP2;
          PH_SKIP2: phase_next = PH_MSEG;
          PH_MSEG: begin
            segment_latch_next = b;
            phase_next         = PH_OFFLO;
          end
          PH_OFFLO: begin
            offset_low_latch_next = b;
            phase_next            = PH_OFFHI;
          end
          PH_OFFHI: begin
            offset                = {b, offset_low_latch_next};
            ordinal_counter_next  = ordinal_counter_next + 16'd1;
            entry                 = 1'b1;
            bundle_remaining_next = bundle_remaining_next - 8'd1;
            phase_next = (bundle_remaining_next == 8'd0) ? PH_COUNT : PH_FLAGS;
          end
          default: phase_next = PH_COUNT;
        endcase

        if (byte_position_next >= table_length) ended = 1'b1;
        if (ended) finished_next = 1'b1;

        step.push                = entry || ended;
        step.beat.table_end      = ended;
        step.beat.entry_valid    = entry;
        step.beat.ordinal        = entry ? ordinal_counter_next : 16'd0;
        step.beat.entry_flags    = entry ? flags_latch_next : 8'd0;
        step.beat.entry_segment  = entry ? segment_latch_next : 8'd0;
        step.beat.entry_offset   = offset;
      end
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_COUNT;
      bundle_remaining <= 8'd0;
      bundle_segment   <= 8'd0;
      flags_latch      <= 8'd0;
      segment_latch    <= 8'd0;
      offset_low_latch <= 8'd0;
      byte_position    <= 16'd0;
      ordinal_counter  <= 16'd0;
      finished         <= 1'b0;
    end else begin
      phase            <= phase_next;
      bundle_remaining <= bundle_remaining_next;
      bundle_segment   <= bundle_segment_next;
      flags_latch      <= flags_latch_next;
      segment_latch    <= segment_latch_next;
      offset_low_latch <= offset_low_latch_next;
      byte_position    <= byte_position_next;
      ordinal_counter  <= ordinal_counter_next;
      finished         <= finished_next;
    end
  end

  // An entry only completes on its high offset byte
  assert property (@(posedge clk) disable iff (rst)
    (step.push && step.beat.entry_valid) |-> (phase == PH_OFFHI))
    else $error("entry completed outside the offset high byte");

  // Table end leaves the parser finished
  assert property (@(posedge clk) disable iff (rst)
    (step.push && step.beat.table_end) |=> finished)
    else $error("table end did not finish the parser");

  // Once finished, nothing is produced until a restart
  assert property (@(posedge clk) disable iff (rst)
    (finished && accept && !in_data.start_of_table) |-> !step.push)
    else $error("result produced after the table ended");

endmodule

/* rtl/core/netp_out_buf.sv */
`timescale 1ns / 1ps

module netp_out_buf import netp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  step_t     step,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  logic      skid_valid;
  out_beat_t skid_data;
  logic      pop;

  assign pop      = out_valid && !out_stall;
  // skid slot full: hold the input side off
  assign in_stall = skid_valid;

  // Output register with one skid slot behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (step.push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Beat payloads
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) out_data <= skid_data;
    end else if (step.push) begin
      if (!out_valid || pop) begin
        out_data <= step.beat;
      end else begin
        skid_data <= step.beat;
      end
    end
  end

  // The skid slot only fills behind a waiting output beat
  assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid slot full with output register empty");

  // A beat without an entry carries zero record fields
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.entry_valid) |->
      (out_data.ordinal == 16'd0 && out_data.entry_offset == 16'd0))
    else $error("record fields set on a beat without an entry");

endmodule

/* rtl/core/ne_entry_table_parser.sv */
`timescale 1ns / 1ps
// Each result beat is registered in the output register, or in the skid slot.
// Throughput: one table byte per cycle unless stalled; state updates in one pass.
// Output register plus one skid slot: one more beat is taken while out is stalled,
// then in_stall holds until the skid slot drains.
// Reset (rst, synchronous) clears the parser, the output valid flags and table_length.

module ne_entry_table_parser import netp_pkg::*; #(
  parameter int unsigned MAX_TABLE_BYTES = 32768
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   out_data
);

  logic [15:0] table_length;
  logic        accept;
  step_t       step;

  assign accept = in_valid && !in_stall;

  // Table length register
  always_ff @(posedge clk) begin
    if (rst) begin
      table_length <= 16'd0;
    end else if (cfg_we) begin
      table_length <= cfg_wdata;
    end
  end

  netp_parser #(
    .MAX_TABLE_BYTES(MAX_TABLE_BYTES)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .in_data      (in_data),
    .table_length (table_length),
    .step         (step)
  );

  netp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* tb/sv/ne_entry_table_parser_test.sv */
`timescale 1ns / 1ps

module ne_entry_table_parser_test;
  import netp_pkg::*;

  localparam int unsigned MAX_TABLE = 32768;
  localparam int QUIET_LIMIT = 4000;
  localparam int ITEMS_PER_PHASE = 300;

  typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [15:0] value;
    logic        start;
    bit          typed;
    bit          has_rec;
    out_beat_t   rec;
  } row_t;

  localparam out_beat_t END_ONLY = '{entry_valid: 1'b0, ordinal: '0, entry_flags: '0,
                                     entry_segment: '0, entry_offset: '0, table_end: 1'b1};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_beat_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_beat_t   out_data;

  ne_entry_table_parser #(.MAX_TABLE_BYTES(MAX_TABLE)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // Parser state as the block should hold it
  logic [15:0] cur_length = '0;
  phase_t      pr_phase = PH_COUNT;
  logic [7:0]  pr_left = '0;
  logic [7:0]  pr_seg = '0;
  logic [15:0] pr_pos = '0;
  logic [15:0] pr_ord = '0;
  logic [7:0]  pr_flags = '0;
  logic [7:0]  pr_eseg = '0;
  logic [7:0]  pr_offlo = '0;
  bit          pr_done = 1'b0;

  out_beat_t   pending_records[$];
  row_t        directed_rows[$];
  int          mismatches = 0;
  int          sent_bytes = 0;
  int          quiet_cycles = 0;
  int          sender_idle_pct = 0;
  int          recv_stall_pct = 0;

  // Advance the parser by one table byte; returns 1 when a record is due
  function automatic bit parse_table_byte(input logic [7:0] b, input logic st,
                                          output out_beat_t rec);
    bit          ended;
    bit          entry;
    logic [15:0] off;
    ended = 1'b0;
    entry = 1'b0;
    off   = '0;
    rec   = '0;
    if (st) begin
      pr_phase = PH_COUNT;
      pr_left  = '0;
      pr_seg   = '0;
      pr_pos   = '0;
      pr_ord   = '0;
      pr_flags = '0;
      pr_eseg  = '0;
      pr_offlo = '0;
      pr_done  = 1'b0;
    end
    if (pr_done) return 1'b0;
    // disabled length, or length already passed: end without parsing
    if (cur_length <= MIN_TABLE_LEN || cur_length > MAX_TABLE || pr_pos >= cur_length) begin
      pr_done = 1'b1;
      rec.table_end = 1'b1;
      return 1'b1;
    end
    pr_pos = pr_pos + 16'd1;
    case (pr_phase)
      PH_COUNT: begin
        if (b == 8'h00) ended = 1'b1;
        else begin
          pr_left  = b;
          pr_phase = PH_SEG;
        end
      end
      PH_SEG: begin
        if (b == 8'h00) ended = 1'b1;
        else begin
          pr_seg   = b;
          pr_phase = PH_FLAGS;
        end
      end
      PH_FLAGS: begin
        pr_flags = b;
        if (pr_seg == SEG_MOVEABLE) pr_phase = PH_SKIP1;
        else begin
          pr_eseg  = pr_seg;
          pr_phase = PH_OFFLO;
        end
      end
      PH_SKIP1: pr_phase = PH_SKIP2;
      PH_SKIP2: pr_phase = PH_MSEG;
      PH_MSEG: begin
        pr_eseg  = b;
        pr_phase = PH_OFFLO;
      end
      PH_OFFLO: begin
        pr_offlo = b;
        pr_phase = PH_OFFHI;
      end
      PH_OFFHI: begin
        off      = {b, pr_offlo};
        pr_ord   = pr_ord + 16'd1;
        entry    = 1'b1;
        pr_left  = pr_left - 8'd1;
        pr_phase = (pr_left == 8'd0) ? PH_COUNT : PH_FLAGS;
      end
      default: pr_phase = PH_COUNT;
    endcase
    if (pr_pos >= cur_length) ended = 1'b1;
    if (ended) pr_done = 1'b1;
    if (entry) begin
      rec.entry_valid   = 1'b1;
      rec.ordinal       = pr_ord;
      rec.entry_flags   = pr_flags;
      rec.entry_segment = pr_eseg;
      rec.entry_offset  = off;
    end
    rec.table_end = ended;
    return entry || ended;
  endfunction

  function automatic out_beat_t entry_rec(input logic [15:0] ord, input logic [7:0] flags,
                                          input logic [7:0] seg, input logic [15:0] off,
                                          input logic last);
    entry_rec = '{entry_valid: 1'b1, ordinal: ord, entry_flags: flags,
                  entry_segment: seg, entry_offset: off, table_end: last};
  endfunction

  function automatic row_t cfg_row(input logic [15:0] v);
    cfg_row = '{kind: ROW_CFG, value: v, start: 1'b0, typed: 1'b0, has_rec: 1'b0, rec: '0};
  endfunction

  function automatic row_t byte_row(input logic [7:0] b, input logic st);
    byte_row = '{kind: ROW_BYTE, value: {8'h00, b}, start: st, typed: 1'b0,
                 has_rec: 1'b0, rec: '0};
  endfunction

  function automatic row_t known_row(input logic [7:0] b, input logic st, input bit has,
                                     input out_beat_t rec);
    known_row = '{kind: ROW_BYTE, value: {8'h00, b}, start: st, typed: 1'b1,
                  has_rec: has, rec: rec};
  endfunction

  // One input beat: random idle, hold through stall, predict on acceptance
  task automatic send_byte(input logic [7:0] b, input logic st, input bit typed,
                           input bit has, input out_beat_t rec);
    out_beat_t pred;
    bit        due;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{table_byte: b, start_of_table: st};
    do @(posedge clk); while (in_stall);
    due = parse_table_byte(b, st, pred);
    if (typed) begin
      if (has) pending_records.push_back(rec);
    end else if (due) begin
      pending_records.push_back(pred);
    end
    sent_bytes++;
    @(negedge clk);
  endtask

  // Drain all records, then allow for a byte still in flight with no record
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_records.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_length(input logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_length = v;
  endtask

  // Random table: mostly well-formed bundles, some noise and broken tails
  task automatic send_random_table();
    logic [7:0]  seq[$];
    int unsigned cnt;
    int unsigned n_ent;
    int          len;
    int          pick;
    logic [7:0]  seg;
    logic        st;
    seq = {};
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 20)) seq.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        cnt = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 255) : $urandom_range(1, 4);
        seg = ($urandom_range(0, 9) < 4) ? SEG_MOVEABLE : 8'($urandom_range(1, 254));
        seq.push_back(8'(cnt));
        seq.push_back(seg);
        n_ent = (cnt > 6) ? 6 : cnt;
        repeat (n_ent * ((seg == SEG_MOVEABLE) ? 6 : 3))
          seq.push_back(8'($urandom_range(0, 255)));
      end
      pick = $urandom_range(0, 5);
      if (pick < 3) begin
        seq.push_back(8'h00);
      end else if (pick == 3) begin
        seq.push_back(8'($urandom_range(1, 255)));
        seq.push_back(8'h00);
      end
      if ($urandom_range(0, 7) == 0) seq = seq[0:$urandom_range(0, seq.size() - 1)];
    end

    // new length now and then, written while idle
    if ($urandom_range(0, 2) == 0) begin
      pick = $urandom_range(0, 19);
      if (pick < 8) len = seq.size();
      else if (pick < 11) len = seq.size() - $urandom_range(1, 3);
      else if (pick < 15) len = $urandom_range(3, 200);
      else if (pick == 15) len = MAX_TABLE;
      else if (pick == 16) len = $urandom_range(0, 2);
      else if (pick == 17) len = $urandom_range(MAX_TABLE + 1, 65535);
      else len = $urandom_range(3, MAX_TABLE);
      if (len < 0) len = 0;
      wait_idle();
      write_length(16'(len));
    end

    // a few tables carry on from the previous one without a restart
    st = ($urandom_range(0, 9) != 0);
    foreach (seq[i])
      send_byte(seq[i], (i == 0) ? st : ($urandom_range(0, 99) == 0), 1'b0, 1'b0, '0);
  endtask

  // Receiver stall
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Check each record beat against the oldest expectation
  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : record_check
    out_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_records.size() == 0) begin
        mismatches++;
        $display("%0t: record expected none got %h", $time, out_data);
      end else begin
        want = pending_records.pop_front();
        compare_field("entry_valid", 16'(want.entry_valid), 16'(out_data.entry_valid));
        compare_field("ordinal", want.ordinal, out_data.ordinal);
        compare_field("entry_flags", 16'(want.entry_flags), 16'(out_data.entry_flags));
        compare_field("entry_segment", 16'(want.entry_segment),
                      16'(out_data.entry_segment));
        compare_field("entry_offset", want.entry_offset, out_data.entry_offset);
        compare_field("table_end", 16'(want.table_end), 16'(out_data.table_end));
      end
    end
  end

  // Watchdog on cycles with no beat moving either way
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("ne_entry_table_parser_test: errors");
      $finish;
    end
  end

  initial begin
    int sender_pcts[4];
    int recv_pcts[4];
    int target;
    sender_pcts = '{0, 53, 0, 29};
    recv_pcts   = '{0, 0, 53, 29};

    // before any start, length still zero from reset
    directed_rows.push_back(known_row(8'h05, 1'b0, 1'b1, END_ONLY));
    // shortest usable table: zero segment, zero count, entry cut short
    directed_rows.push_back(cfg_row(16'd3));
    directed_rows.push_back(byte_row(8'h01, 1'b1));
    directed_rows.push_back(known_row(8'h00, 1'b0, 1'b1, END_ONLY));
    directed_rows.push_back(known_row(8'h00, 1'b1, 1'b1, END_ONLY));
    directed_rows.push_back(byte_row(8'h01, 1'b1));
    directed_rows.push_back(byte_row(8'h05, 1'b0));
    directed_rows.push_back(known_row(8'h80, 1'b0, 1'b1, END_ONLY));
    // longest table, one moveable entry
    directed_rows.push_back(cfg_row(16'(MAX_TABLE)));
    directed_rows.push_back(byte_row(8'h02, 1'b1));
    directed_rows.push_back(byte_row(SEG_MOVEABLE, 1'b0));
    directed_rows.push_back(byte_row(8'hFE, 1'b0));
    directed_rows.push_back(byte_row(8'h00, 1'b0));
    directed_rows.push_back(byte_row(8'hFF, 1'b0));
    directed_rows.push_back(byte_row(8'h00, 1'b0));
    directed_rows.push_back(byte_row(8'hFF, 1'b0));
    directed_rows.push_back(known_row(8'h00, 1'b0, 1'b1,
                                      entry_rec(16'd1, 8'hFE, 8'h00, 16'h00FF, 1'b0)));
    directed_rows.push_back(byte_row(8'h01, 1'b0));
    // length lowered below the bytes already taken
    directed_rows.push_back(cfg_row(16'd5));
    directed_rows.push_back(known_row(8'h33, 1'b0, 1'b1, END_ONLY));
    // disabled lengths
    directed_rows.push_back(cfg_row(16'hFFFF));
    directed_rows.push_back(known_row(8'h01, 1'b1, 1'b1, END_ONLY));
    directed_rows.push_back(cfg_row(16'd0));
    directed_rows.push_back(known_row(8'h01, 1'b1, 1'b1, END_ONLY));
    directed_rows.push_back(cfg_row(16'd2));
    directed_rows.push_back(known_row(8'h01, 1'b1, 1'b1, END_ONLY));
    // fixed entry whose last byte is the last byte of the table, then a dead byte
    directed_rows.push_back(cfg_row(16'd5));
    directed_rows.push_back(byte_row(8'h01, 1'b1));
    directed_rows.push_back(byte_row(8'hFE, 1'b0));
    directed_rows.push_back(byte_row(8'h01, 1'b0));
    directed_rows.push_back(byte_row(8'h00, 1'b0));
    directed_rows.push_back(known_row(8'h80, 1'b0, 1'b1,
                                      entry_rec(16'd1, 8'h01, 8'hFE, 16'h8000, 1'b1)));
    directed_rows.push_back(known_row(8'h00, 1'b0, 1'b0, '0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        wait_idle();
        write_length(directed_rows[i].value);
      end else begin
        send_byte(directed_rows[i].value[7:0], directed_rows[i].start,
                  directed_rows[i].typed, directed_rows[i].has_rec, directed_rows[i].rec);
      end
    end

    // random tables under each idling pattern
    target = sent_bytes;
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      sender_idle_pct = sender_pcts[p];
      recv_stall_pct  = recv_pcts[p];
      write_length(16'($urandom_range(3, 120)));
      target += ITEMS_PER_PHASE;
      while (sent_bytes < target) send_random_table();
    end

    in_valid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("ne_entry_table_parser_test: clean");
    end else begin
      $display("ne_entry_table_parser_test: errors");
    end
    $finish;
  end

endmodule
